// ----- hdl/spti_pkg.sv -----
// Shared types and constants for the sorted point table interpolator.
// No dependencies.
package spti_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned DivSteps    = 32;

  localparam logic KindInsert = 1'b0;
  localparam logic KindQuery  = 1'b1;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StNew   = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;
  localparam logic [1:0] StEmpty = 2'd3;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } spti_in_t;

  typedef struct packed {
    logic signed [31:0] y_result;
    logic [1:0]         status;
  } spti_out_t;

  // what a cell hands to its right neighbor
  typedef struct packed {
    logic               valid;
    logic               le;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } spti_link_t;

  // masked per-cell contribution to the query reduction
  typedef struct packed {
    logic               bracket;
    logic signed [31:0] x1;
    logic signed [31:0] x2;
    logic signed [31:0] y1;
    logic signed [31:0] y2;
    logic signed [31:0] ylast;
  } spti_hit_t;

endpackage

// ----- hdl/spti_cell.sv -----
// One table slot: holds a point, shifts right on sorted insert.
// Depends on spti_pkg.
module spti_cell (
  input  logic                clk,
  input  logic                ins_en,
  input  logic                match_any,
  input  logic signed [31:0]  key_x,
  input  logic signed [31:0]  key_y,
  input  logic                valid_i,
  input  logic                next_valid,
  input  spti_pkg::spti_link_t prev,
  output spti_pkg::spti_link_t link_o,
  output logic                eq_o,
  output spti_pkg::spti_hit_t hit_o
);
  import spti_pkg::*;

  logic signed [31:0] x_r, y_r;
  logic               le, gt_left, self_gt, ins_ok, brk, last;

  assign le      = valid_i & (key_x <= x_r);
  assign eq_o    = valid_i & (key_x == x_r);
  assign link_o  = '{valid: valid_i, le: le, x: x_r, y: y_r};
  assign gt_left = prev.valid & prev.le;
  assign self_gt = !valid_i | (key_x < x_r);
  assign ins_ok  = valid_i | prev.valid;
  assign brk     = prev.valid & !prev.le & le;
  assign last    = valid_i & !next_valid;

  assign hit_o = '{bracket: brk,
                   x1: brk ? prev.x : 32'sd0,
                   x2: brk ? x_r    : 32'sd0,
                   y1: brk ? prev.y : 32'sd0,
                   y2: brk ? y_r    : 32'sd0,
                   ylast: last ? y_r : 32'sd0};

  always_ff @(posedge clk) begin
    if (ins_en) begin
      if (match_any) begin
        if (eq_o) begin
          y_r <= key_y;
        end
      end else if (ins_ok) begin
        if (gt_left) begin
          x_r <= prev.x;
          y_r <= prev.y;
        end else if (self_gt) begin
          x_r <= key_x;
          y_r <= key_y;
        end
      end
    end
  end

endmodule

// ----- hdl/sorted_point_table_interpolator_unit.sv -----
// Top level: row of point cells, query reduction, multiply and serial divider.
// Depends on spti_pkg and spti_cell.
//
// Usage: items arrive on in_valid/in_stall/in_data; one result beat per item
// leaves on out_valid/out_stall/out_data. An insert (kind 0) overwrites the
// point with equal x, or places it in sorted order, or is dropped with status
// full. A query (kind 1) returns the clamped or linearly interpolated y.
// One item is in work at a time; in_stall is high while it is.
// Steps: an insert runs a scan and the output load; a query clamped at
// either end or on an empty table runs the same, an interior query one scan,
// one multiply, one add, 32 restoring divide steps and the output load.
// The finished beat sits in an output register; the next item is taken while
// it waits, and a stalled receiver only holds back the following result.
// Reset empties the table (count to zero) and clears the output valid.
module sorted_point_table_interpolator_unit #(
  parameter int unsigned CAPACITY = spti_pkg::CapacityDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  spti_pkg::spti_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output spti_pkg::spti_out_t out_data
);
  import spti_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = $clog2(DivSteps);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_MUL, S_ADD, S_DIV, S_DONE} state_t;

  state_t             state_r;
  spti_in_t           key_r;
  logic [CW-1:0]      count_r;
  spti_out_t          res_r, out_r;
  logic               out_valid_r;
  logic [32:0]        a_r, b_r, d_r;
  logic signed [31:0] y1_r, y2_r;
  logic signed [65:0] p1_r, p2_r;
  logic               neg_r;
  logic [33:0]        rem_r;
  logic [31:0]        q_r;
  logic [SW-1:0]      step_r;

  spti_link_t         links [CAPACITY];
  spti_hit_t          hits  [CAPACITY];
  logic [CAPACITY-1:0] eqs, valids;
  spti_hit_t          hit_or;
  logic               match_any, any_le, full, ins_en;
  spti_link_t         head;

  assign full     = (count_r == CW'(CAPACITY));
  assign match_any = |eqs;
  assign ins_en   = (state_r == S_SCAN) && (key_r.kind == KindInsert) && (match_any || !full);
  assign head     = '{valid: 1'b1, le: 1'b0, x: 32'sd0, y: 32'sd0};

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign valids[g] = (CW'(g) < count_r);
      spti_cell u_cell (
        .clk        (clk),
        .ins_en     (ins_en),
        .match_any  (match_any),
        .key_x      (key_r.x_value),
        .key_y      (key_r.y_value),
        .valid_i    (valids[g]),
        .next_valid ((g == CAPACITY - 1) ? 1'b0 : valids[(g + 1) % CAPACITY]),
        .prev       ((g == 0) ? head : links[(g + CAPACITY - 1) % CAPACITY]),
        .link_o     (links[g]),
        .eq_o       (eqs[g]),
        .hit_o      (hits[g])
      );
    end
  endgenerate

  always_comb begin
    hit_or = '0;
    any_le = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_or = hit_or | hits[i];
      any_le = any_le | links[i].le;
    end
  end

  logic signed [63:0] num;
  logic [63:0]        mag;
  logic [33:0]        shifted;
  logic               take;
  assign num     = p1_r[63:0] + p2_r[63:0];
  assign mag     = num[63] ? (64'd0 - num) : num;
  assign shifted = {rem_r[32:0], q_r[31]};
  assign take    = (shifted >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            key_r   <= in_data;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (key_r.kind == KindInsert) begin
            res_r.y_result <= 32'sd0;
            state_r        <= S_DONE;
            if (match_any) begin
              res_r.status <= StOk;
            end else if (full) begin
              res_r.status <= StFull;
            end else begin
              res_r.status <= StNew;
              count_r      <= count_r + CW'(1);
            end
          end else if (count_r == '0) begin
            res_r.y_result <= 32'sd0;
            res_r.status   <= StEmpty;
            state_r        <= S_DONE;
          end else begin
            res_r.status <= StOk;
            if (links[0].le) begin
              res_r.y_result <= links[0].y;
              state_r        <= S_DONE;
            end else if (!any_le) begin
              res_r.y_result <= hit_or.ylast;
              state_r        <= S_DONE;
            end else begin
              a_r     <= 33'({key_r.x_value[31], key_r.x_value} -
                             {hit_or.x1[31], hit_or.x1});
              b_r     <= 33'({hit_or.x2[31], hit_or.x2} -
                             {key_r.x_value[31], key_r.x_value});
              d_r     <= 33'({hit_or.x2[31], hit_or.x2} - {hit_or.x1[31], hit_or.x1});
              y1_r    <= hit_or.y1;
              y2_r    <= hit_or.y2;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          p1_r    <= $signed({1'b0, a_r}) * y2_r;
          p2_r    <= $signed({1'b0, b_r}) * y1_r;
          state_r <= S_ADD;
        end
        S_ADD: begin
          neg_r   <= num[63];
          rem_r   <= {2'b00, mag[63:32]};
          q_r     <= mag[31:0];
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= take ? (shifted - {1'b0, d_r}) : shifted;
          q_r    <= {q_r[30:0], take};
          step_r <= step_r + SW'(1);
          if (step_r == SW'(DivSteps - 1)) begin
            res_r.y_result <= neg_r ? -$signed({q_r[30:0], take})
                                    : $signed({q_r[30:0], take});
            state_r        <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("point count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + CW'(1)))
    else $error("point count moved by other than one");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == StEmpty) |-> (out_data.y_result == 32'sd0))
    else $error("empty query with nonzero y");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_r.status == StFull) |-> full)
    else $error("drop flagged with room in table");

endmodule

// ----- test/sorted_point_table_interpolator_unit_test.sv -----
// Testbench for sorted_point_table_interpolator_unit: random and directed inserts
// and queries, checked beat by beat against a behavioral table model.
// Depends on spti_pkg and the unit under test.
module sorted_point_table_interpolator_unit_test;
  import spti_pkg::*;

  localparam int Cap = 64;
  localparam int WatchLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  spti_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  spti_out_t out_data;

  sorted_point_table_interpolator_unit dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic signed [31:0] table_x [Cap];
  logic signed [31:0] table_y [Cap];
  int point_count = 0;
  spti_out_t expected_beats [$];
  int errors = 0;
  int idle_cycles = 0;
  int beats_checked = 0;
  int n_inserts = 0;
  int n_queries = 0;
  int stall_mode = 0;

  function automatic spti_out_t predict_item(spti_in_t item);
    spti_out_t r;
    int pos;
    longint signed a, b, d, num;
    r = '0;
    if (item.kind == KindInsert) begin
      pos = point_count;
      for (int i = 0; i < point_count; i++) begin
        if (table_x[i] == item.x_value) begin
          table_y[i] = item.y_value;
          r.status = StOk;
          return r;
        end
        if (table_x[i] > item.x_value) begin
          pos = i;
          break;
        end
      end
      if (point_count >= Cap) begin
        r.status = StFull;
        return r;
      end
      for (int i = point_count; i > pos; i--) begin
        table_x[i] = table_x[i-1];
        table_y[i] = table_y[i-1];
      end
      table_x[pos] = item.x_value;
      table_y[pos] = item.y_value;
      point_count++;
      r.status = StNew;
      return r;
    end
    if (point_count == 0) begin
      r.status = StEmpty;
      return r;
    end
    r.status = StOk;
    if (item.x_value <= table_x[0]) begin
      r.y_result = table_y[0];
      return r;
    end
    if (item.x_value >= table_x[point_count-1]) begin
      r.y_result = table_y[point_count-1];
      return r;
    end
    for (int j = 1; j < point_count; j++) begin
      if (item.x_value <= table_x[j]) begin
        a = longint'(item.x_value) - longint'(table_x[j-1]);
        b = longint'(table_x[j]) - longint'(item.x_value);
        d = longint'(table_x[j]) - longint'(table_x[j-1]);
        num = a * longint'(table_y[j]) + b * longint'(table_y[j-1]);
        r.y_result = 32'(num / d);
        return r;
      end
    end
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(input logic kind, input logic signed [31:0] x,
                           input logic signed [31:0] y);
    spti_in_t item;
    int g;
    item.kind = kind;
    item.x_value = x;
    item.y_value = y;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_data <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_beats.push_back(predict_item(item));
    if (kind == KindInsert) n_inserts++;
    else n_queries++;
  endtask

  always @(negedge clk) begin
    if (stall_mode == 0) out_stall <= 1'b0;
    else if (stall_mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 19) == 0) ? ~out_stall : out_stall;
  end

  always @(posedge clk) begin
    spti_out_t exp_beat;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        beats_checked++;
        if (expected_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat y=%0d status=%0d", $time,
                   out_data.y_result, out_data.status);
        end else begin
          exp_beat = expected_beats.pop_front();
          if (exp_beat.y_result !== out_data.y_result) begin
            errors++;
            $display("%0t: y_result expected %0d actual %0d", $time,
                     exp_beat.y_result, out_data.y_result);
          end
          if (exp_beat.status !== out_data.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_beat.status, out_data.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WatchLimit) begin
      $display("%0t: timeout, %0d beats outstanding", $time, expected_beats.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff - $urandom_range(0, 3);
      1: return 32'sh80000000 + $urandom_range(0, 3);
      2: return $signed(32'($urandom_range(0, 20)) - 32'sd10);
      default: return $signed($urandom());
    endcase
  endfunction

  // empty table, single point, extremes, interior exact hits, overwrite
  task automatic test_directed();
    send_item(KindQuery, 32'sh80000000, 32'sh7fffffff);
    send_item(KindQuery, 32'sh7fffffff, 0);
    send_item(KindInsert, 0, 32'sh00010000);
    send_item(KindQuery, -5, 0);
    send_item(KindQuery, 5, 0);
    send_item(KindInsert, 32'sh80000000, 32'sh80000000);
    send_item(KindInsert, 32'sh7fffffff, 32'sh7fffffff);
    send_item(KindQuery, 32'sh80000000, 0);
    send_item(KindQuery, 32'sh7fffffff, 0);
    send_item(KindQuery, 32'sh80000001, 0);
    send_item(KindQuery, 32'sh7ffffffe, 0);
    send_item(KindQuery, 0, 0);
    send_item(KindQuery, -1, 0);
    send_item(KindQuery, 1, 0);
    send_item(KindInsert, 0, -32'sh00030000);
    send_item(KindQuery, 0, 0);
    send_item(KindQuery, 32'sh40000000, 0);
    send_item(KindQuery, -32'sh40000000, 0);
    send_item(KindInsert, 100, 7);
    send_item(KindInsert, 103, -7);
    send_item(KindQuery, 101, 0);
    send_item(KindQuery, 102, 0);
  endtask

  // fill the table to capacity, then drop, overwrite and query while full
  task automatic test_full_table();
    logic signed [31:0] x;
    while (point_count < Cap) send_item(KindInsert, rand_word(), rand_word());
    for (int i = 0; i < 40; i++) begin
      x = ($urandom_range(0, 1)) ? table_x[$urandom_range(0, Cap-1)] : rand_word();
      send_item($urandom_range(0, 2) == 0 ? KindInsert : KindQuery, x, rand_word());
    end
  endtask

  // random mix: queries mostly inside the occupied range
  task automatic test_random_mix(input int items);
    logic signed [31:0] x;
    int k;
    for (int i = 0; i < items; i++) begin
      if (i % 150 == 0) stall_mode = $urandom_range(0, 2);
      if (point_count >= 2 && $urandom_range(0, 9) < 7) begin
        k = $urandom_range(1, point_count - 1);
        case ($urandom_range(0, 3))
          0: x = table_x[k];
          1: x = table_x[k] - 1;
          default: x = $signed(32'((longint'(table_x[k-1]) + longint'(table_x[k])) / 2
                       + $signed(32'($urandom_range(0, 6)) - 3)));
        endcase
        send_item(KindQuery, x, $signed($urandom()));
      end else begin
        send_item(($urandom_range(0, 2) == 0) ? KindQuery : KindInsert,
                  rand_word(), rand_word());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    stall_mode = 1;
    test_full_table();
    test_random_mix(540);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d inserts and %0d queries, %0d result beats checked.",
             n_inserts, n_queries, beats_checked);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/spti_pkg.sv
hdl/spti_cell.sv
hdl/sorted_point_table_interpolator_unit.sv
test/sorted_point_table_interpolator_unit_test.sv
